// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bos_pkg.sv =====
package bos_pkg;

	// Field and register widths
	localparam int FIELD_W   = 16;
	localparam int PCT_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CONTAINMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP     = 2'd1;

	// Register reset values and the percent scale
	localparam logic [PCT_W-1:0] PCT_CONT_RST = 7'd90;
	localparam logic [PCT_W-1:0] PCT_OVL_RST  = 7'd60;
	localparam logic [PCT_W-1:0] HUNDRED      = 7'd100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_I_CHK,
		ST_RD_I,
		ST_LD_I,
		ST_J_CHK,
		ST_RD_J,
		ST_WAIT,
		ST_DECIDE,
		ST_E_CHK,
		ST_E_RD,
		ST_E_LD
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_i;
		logic load_out;
		logic out_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cont_fire;
		logic ov_fire;
		logic i_ge_j;
		logic out_busy;
	} status_t;

endpackage

// ===== hdl/bos_ram.sv =====
module bos_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/bos_ctrl.sv =====
module bos_ctrl #(
	parameter int MAX_BOXES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_last,
	output logic                         in_ready,
	output logic                         wr_en,
	output logic [$clog2(MAX_BOXES)-1:0] wr_addr,
	output logic                         rd_en,
	output logic [$clog2(MAX_BOXES)-1:0] rd_addr,
	output bos_pkg::cmd_t                cmd,
	input  bos_pkg::status_t             status
);

	localparam int AW   = $clog2(MAX_BOXES);
	localparam int CNTW = $clog2(MAX_BOXES + 1);
	localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_BOXES);
	localparam logic [CNTW-1:0] ONE  = CNTW'(1);

	bos_pkg::state_t state_q, state_nx;

	logic [CNTW-1:0]      count_q, n_q, i_q, j_q, e_q, count_nx;
	logic [1:0]           wait_q;
	logic [MAX_BOXES-1:0] keep_q;
	logic                 accept, has_room, keep_i, keep_j, keep_e, later_kept;

	assign accept   = in_valid && in_ready;
	assign has_room = count_q < MAXC;
	assign count_nx = has_room ? count_q + ONE : count_q;
	assign keep_i   = keep_q[i_q[AW-1:0]];
	assign keep_j   = keep_q[j_q[AW-1:0]];
	assign keep_e   = keep_q[e_q[AW-1:0]];

	// Any kept box after the one being emitted
	always_comb begin
		later_kept = 1'b0;
		for (int k = 0; k < MAX_BOXES; k++) begin
			if (keep_q[k] && (CNTW'(k) > e_q)) begin
				later_kept = 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bos_pkg::ST_IDLE: begin
				if (accept && in_last) state_nx = bos_pkg::ST_I_CHK;
			end
			bos_pkg::ST_I_CHK: begin
				if (i_q >= n_q) state_nx = bos_pkg::ST_E_CHK;
				else if (keep_i) state_nx = bos_pkg::ST_RD_I;
			end
			bos_pkg::ST_RD_I: state_nx = bos_pkg::ST_LD_I;
			bos_pkg::ST_LD_I: state_nx = bos_pkg::ST_J_CHK;
			bos_pkg::ST_J_CHK: begin
				if (j_q >= n_q) state_nx = bos_pkg::ST_I_CHK;
				else if (keep_j) state_nx = bos_pkg::ST_RD_J;
			end
			bos_pkg::ST_RD_J: state_nx = bos_pkg::ST_WAIT;
			bos_pkg::ST_WAIT: begin
				if (wait_q == 2'd3) state_nx = bos_pkg::ST_DECIDE;
			end
			bos_pkg::ST_DECIDE: begin
				if (status.cont_fire) begin
					state_nx = status.i_ge_j ? bos_pkg::ST_I_CHK : bos_pkg::ST_J_CHK;
				end else if (status.ov_fire) begin
					state_nx = status.i_ge_j ? bos_pkg::ST_J_CHK : bos_pkg::ST_I_CHK;
				end else begin
					state_nx = bos_pkg::ST_J_CHK;
				end
			end
			bos_pkg::ST_E_CHK: begin
				if (e_q >= n_q) state_nx = bos_pkg::ST_IDLE;
				else if (keep_e) state_nx = bos_pkg::ST_E_RD;
			end
			bos_pkg::ST_E_RD: begin
				if (!status.out_busy) state_nx = bos_pkg::ST_E_LD;
			end
			bos_pkg::ST_E_LD: state_nx = bos_pkg::ST_E_CHK;
			default: state_nx = bos_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = count_q[AW-1:0];
		rd_en        = 1'b0;
		rd_addr      = i_q[AW-1:0];
		cmd.load_i   = 1'b0;
		cmd.load_out = 1'b0;
		cmd.out_last = !later_kept;
		case (state_q)
			bos_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				wr_en    = in_valid && has_room;
			end
			bos_pkg::ST_RD_I: rd_en = 1'b1;
			bos_pkg::ST_LD_I: cmd.load_i = 1'b1;
			bos_pkg::ST_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = j_q[AW-1:0];
			end
			bos_pkg::ST_E_RD: begin
				rd_en   = !status.out_busy;
				rd_addr = e_q[AW-1:0];
			end
			bos_pkg::ST_E_LD: cmd.load_out = 1'b1;
			default: ;
		endcase
	end

	// State, indexes and keep marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bos_pkg::ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			e_q     <= '0;
			wait_q  <= '0;
			keep_q  <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				bos_pkg::ST_IDLE: begin
					if (accept) begin
						// Mark the new box kept, drop marks of the previous set
						if (has_room) begin
							for (int k = 0; k < MAX_BOXES; k++) begin
								keep_q[k] <= (CNTW'(k) == count_q) ||
									((count_q != '0) && keep_q[k]);
							end
						end
						count_q <= count_nx;
						if (in_last) begin
							n_q <= count_nx;
							i_q <= '0;
						end
					end
				end
				bos_pkg::ST_I_CHK: begin
					if (i_q >= n_q) e_q <= '0;
					else if (!keep_i) i_q <= i_q + ONE;
				end
				bos_pkg::ST_LD_I: j_q <= i_q + ONE;
				bos_pkg::ST_J_CHK: begin
					if (j_q >= n_q) i_q <= i_q + ONE;
					else if (!keep_j) j_q <= j_q + ONE;
				end
				bos_pkg::ST_RD_J: wait_q <= '0;
				bos_pkg::ST_WAIT: wait_q <= wait_q + 2'd1;
				bos_pkg::ST_DECIDE: begin
					// Drop the larger box on containment, the smaller on overlap
					if (status.cont_fire) begin
						if (status.i_ge_j) begin
							keep_q[i_q[AW-1:0]] <= 1'b0;
							i_q <= i_q + ONE;
						end else begin
							keep_q[j_q[AW-1:0]] <= 1'b0;
							j_q <= j_q + ONE;
						end
					end else if (status.ov_fire) begin
						if (status.i_ge_j) begin
							keep_q[j_q[AW-1:0]] <= 1'b0;
							j_q <= j_q + ONE;
						end else begin
							keep_q[i_q[AW-1:0]] <= 1'b0;
							i_q <= i_q + ONE;
						end
					end else begin
						j_q <= j_q + ONE;
					end
				end
				bos_pkg::ST_E_CHK: begin
					if (e_q >= n_q) count_q <= '0;
					else if (!keep_e) e_q <= e_q + ONE;
				end
				bos_pkg::ST_E_LD: e_q <= e_q + ONE;
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/bos_datapath.sv =====
module bos_datapath #(
	parameter int COORD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [bos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bos_pkg::PCT_W-1:0]        cfg_data,
	input  logic [4*((COORD_BITS < bos_pkg::FIELD_W) ? COORD_BITS : bos_pkg::FIELD_W)-1:0]
		rd_data,
	input  bos_pkg::cmd_t                    cmd,
	output bos_pkg::status_t                 status,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [4*bos_pkg::FIELD_W-1:0]    m_tdata,
	output logic                             m_tlast
);

	localparam int CW     = (COORD_BITS < bos_pkg::FIELD_W) ? COORD_BITS : bos_pkg::FIELD_W;
	localparam int FW     = bos_pkg::FIELD_W;
	localparam int AREA_W = 2 * CW;
	localparam int PROD_W = AREA_W + bos_pkg::PCT_W;
	localparam int UNI_W  = AREA_W + 1;
	localparam int OPR_W  = UNI_W + bos_pkg::PCT_W;

	logic [bos_pkg::PCT_W-1:0] cont_pct_q, ovl_pct_q;

	logic [CW-1:0]     bl_q, bt_q, br_q, bb_q, jl, jt, jr, jb;
	logic [CW-1:0]     wi, hi, ix0, iy0, ix1, iy1;
	logic [AREA_W-1:0] ai_q, smaller;

	logic [CW-1:0]     dx_s1, dy_s1, wj_s1, hj_s1;
	logic              ovl_s1, ovl_s2, ovl_s3, ovl_s4, ige_s3, ige_s4, cont_s4;
	logic [AREA_W-1:0] inter_s2, aj_s2;
	logic [PROD_W-1:0] cl_s3, cr_s3;
	logic [UNI_W-1:0]  uni_s3;
	logic [OPR_W-1:0]  ol_s4, or_s4;
	logic              out_valid_q, out_last_q;
	logic [4*CW-1:0]   out_box_q;

	// Percent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_pct_q <= bos_pkg::PCT_CONT_RST;
			ovl_pct_q  <= bos_pkg::PCT_OVL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bos_pkg::CFG_CONTAINMENT: cont_pct_q <= cfg_data;
				bos_pkg::CFG_OVERLAP:     ovl_pct_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign jl = rd_data[0 +: CW];
	assign jt = rd_data[CW +: CW];
	assign jr = rd_data[2*CW +: CW];
	assign jb = rd_data[3*CW +: CW];

	// Box i and its area, held for the whole scan
	assign wi = (br_q > bl_q) ? br_q - bl_q : '0;
	assign hi = (bb_q > bt_q) ? bb_q - bt_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_i) begin
			bl_q <= jl;
			bt_q <= jt;
			br_q <= jr;
			bb_q <= jb;
		end
		ai_q <= AREA_W'(wi) * AREA_W'(hi);
	end

	// Intersection edges of box i and the box being read
	assign ix0 = (bl_q > jl) ? bl_q : jl;
	assign iy0 = (bt_q > jt) ? bt_q : jt;
	assign ix1 = (br_q < jr) ? br_q : jr;
	assign iy1 = (bb_q < jb) ? bb_q : jb;
	assign smaller = (ai_q < aj_s2) ? ai_q : aj_s2;

	// Pair pipeline: extents, products, scaled terms, compares
	always_ff @(posedge clk) begin
		ovl_s1   <= (ix1 > ix0) && (iy1 > iy0);
		dx_s1    <= ix1 - ix0;
		dy_s1    <= iy1 - iy0;
		wj_s1    <= (jr > jl) ? jr - jl : '0;
		hj_s1    <= (jb > jt) ? jb - jt : '0;

		ovl_s2   <= ovl_s1;
		inter_s2 <= AREA_W'(dx_s1) * AREA_W'(dy_s1);
		aj_s2    <= AREA_W'(wj_s1) * AREA_W'(hj_s1);

		ovl_s3   <= ovl_s2;
		ige_s3   <= ai_q >= aj_s2;
		cl_s3    <= PROD_W'(inter_s2) * PROD_W'(bos_pkg::HUNDRED);
		cr_s3    <= PROD_W'(cont_pct_q) * PROD_W'(smaller);
		uni_s3   <= UNI_W'(ai_q) + UNI_W'(aj_s2) - UNI_W'(inter_s2);

		ovl_s4   <= ovl_s3;
		ige_s4   <= ige_s3;
		cont_s4  <= ovl_s3 && (cl_s3 > cr_s3);
		ol_s4    <= OPR_W'(cl_s3);
		or_s4    <= OPR_W'(ovl_pct_q) * OPR_W'(uni_s3);
	end

	assign status.cont_fire = cont_s4;
	assign status.ov_fire   = ovl_s4 && (ol_s4 > or_s4);
	assign status.i_ge_j    = ige_s4;
	assign status.out_busy  = out_valid_q;

	// Output register: fill on command, free when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_box_q  <= rd_data;
			out_last_q <= cmd.out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {FW'(out_box_q[3*CW +: CW]), FW'(out_box_q[2*CW +: CW]),
		FW'(out_box_q[CW +: CW]), FW'(out_box_q[0 +: CW])};

endmodule

// ===== hdl/box_overlap_suppression_core.sv =====
// Loading: one box per cycle, the box marked last starts suppression.
// Suppression: each kept box i is fetched, then compared with each later kept box in turn
// through the single store read port and the pair pipeline; boxes not kept are skipped.
// Emission: each survivor waits for a free output register; dropped boxes are skipped.
// Reset clears control state and sets the percent registers to 90 and 60;
// the box store holds no defined data until loaded.
`include "assert_macros.svh"

module box_overlap_suppression_core #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_left, cell_top, cell_right, cell_bottom
	input  logic [4*bos_pkg::FIELD_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_left, out_top, out_right, out_bottom
	output logic [4*bos_pkg::FIELD_W-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bos_pkg::PCT_W-1:0]     cfg_data
);

	localparam int CW = (COORD_BITS < bos_pkg::FIELD_W) ? COORD_BITS : bos_pkg::FIELD_W;
	localparam int FW = bos_pkg::FIELD_W;
	localparam int AW = $clog2(MAX_BOXES);

	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [4*CW-1:0]   wr_data, rd_data;
	bos_pkg::cmd_t     cmd;
	bos_pkg::status_t  status;

	assign cfg_ready = 1'b1;

	// Keep the coordinate bits of each edge
	assign wr_data = {s_tdata[3*FW +: CW], s_tdata[2*FW +: CW],
		s_tdata[FW +: CW], s_tdata[0 +: CW]};

	bos_ram #(.WIDTH(4 * CW), .DEPTH(MAX_BOXES)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bos_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.cmd      (cmd),
		.status   (status)
	);

	bos_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_data   (rd_data),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Loading and scanning never share a cycle on the store
	`ASSERT_ALWAYS(a_no_rw_overlap, clk, arst_n, !(wr_en && rd_en), "store read during load")
	// A survivor is only loaded into an empty output register
	`ASSERT_IMPLIES(a_out_free, clk, arst_n, cmd.load_out, !m_tvalid, "output overwritten")
	// The store is written only while requests are taken
	`ASSERT_IMPLIES(a_wr_on_req, clk, arst_n, wr_en, s_tvalid && s_tready, "stray store write")

endmodule
